>>> design/rcsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcsc_pkg
// Shared types and constants of the radio channel scan controller: host link
// codes, result kinds and the job word passed from front end to back end.
// ----------------------------------------------------------------------------
package rcsc_pkg;

    localparam logic [7:0] CMD_CHANGE_CHAN = 8'h00;
    localparam logic [7:0] RPT_RECEIVED    = 8'h02;
    localparam logic [7:0] CMD_BEACON      = 8'h04;
    localparam logic [7:0] CMD_START_SCAN  = 8'h05;
    localparam logic [7:0] RPT_SCAN_DONE   = 8'h06;
    localparam logic [7:0] RPT_CHANNEL_IS  = 8'h07;
    localparam logic [7:0] HIGHEST_RESET   = 8'd15;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_HOST    = 2'd1;
    localparam logic [1:0] OP_HEADER  = 2'd2;
    localparam logic [1:0] OP_PAYLOAD = 2'd3;

    localparam logic [1:0] KIND_HOST   = 2'd0;
    localparam logic [1:0] KIND_BEACON = 2'd1;
    localparam logic [1:0] KIND_TUNE   = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        JOB_NONE        = 3'd0,
        JOB_BEACON      = 3'd1,
        JOB_SET         = 3'd2,
        JOB_SET_DONE    = 3'd3,
        JOB_SET_BEACON  = 3'd4,
        JOB_HEADER      = 3'd5,
        JOB_PAYLOAD     = 3'd6
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [7:0]  chan;
        logic [7:0]  link_quality;
        logic [31:0] receive_time;
        logic [6:0]  frame_length;
    } t_job;

endpackage
`default_nettype wire

>>> design/radio_channel_scan_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radio_channel_scan_controller
// Host-link and channel scan controller: timer ticks, host commands and
// received frames in; host bytes, beacon requests and tune actions out.
//
// The front end takes one input word per clock while its four-entry job
// queue has room, updating the scan state at once. The back end emits one
// result word per clock from the job at the queue head while the output
// is taken; each item yields no words for most ticks and commands, one
// for a beacon or payload byte, three or four for a channel change, eight
// for a frame header. The output register lets a new word be formed while
// the previous one is being taken.
// ----------------------------------------------------------------------------
module radio_channel_scan_controller (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [7:0]  i_cfg_wdata,     // highest_scan_channel
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // host_byte[7:0], link_quality[15:8], receive_time[47:16],
    // frame_length[54:48], payload_byte[62:55], zero[63]
    input  wire  [63:0] i_s_axis_tdata,
    input  wire  [1:0]  i_s_axis_tuser,  // op[1:0]
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // value[7:0]
    output logic [1:0]  o_m_axis_tuser,  // kind[1:0]
    output logic        o_m_axis_tlast
);
    import rcsc_pkg::*;

    logic accept;
    logic push;
    logic pop;
    logic full;
    logic empty;
    t_job front_job;
    t_job head_job;

    assign o_s_axis_tready = !full;
    assign accept          = i_s_axis_tvalid && !full;

    rcsc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_accept       (accept),
        .i_op           (i_s_axis_tuser),
        .i_host_byte    (i_s_axis_tdata[7:0]),
        .i_link_quality (i_s_axis_tdata[15:8]),
        .i_receive_time (i_s_axis_tdata[47:16]),
        .i_frame_length (i_s_axis_tdata[54:48]),
        .i_payload_byte (i_s_axis_tdata[62:55]),
        .o_push         (push),
        .o_job          (front_job)
    );

    rcsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_job   (head_job)
    );

    rcsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_kind  (o_m_axis_tuser),
        .o_value (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

endmodule
`default_nettype wire

>>> design/rcsc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcsc_front
// Front end: takes one input word per cycle while accepted, keeps scan and
// channel state and turns each word with results into a back-end job.
// ----------------------------------------------------------------------------
module rcsc_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire  [7:0]          i_cfg_wdata,
    input  wire                 i_accept,
    input  wire  [1:0]          i_op,
    input  wire  [7:0]          i_host_byte,
    input  wire  [7:0]          i_link_quality,
    input  wire  [31:0]         i_receive_time,
    input  wire  [6:0]          i_frame_length,
    input  wire  [7:0]          i_payload_byte,
    output logic                o_push,
    output rcsc_pkg::t_job      o_job
);
    import rcsc_pkg::*;

    logic [7:0] r_highest;
    logic [1:0] r_phase,   n_phase;
    logic       r_scan,    n_scan;
    logic [7:0] r_index,   n_index;
    logic [7:0] r_cur,     n_cur;
    logic [7:0] r_saved,   n_saved;
    logic       r_pending, n_pending;
    t_job       job;

    always_comb begin
        n_phase   = r_phase;
        n_scan    = r_scan;
        n_index   = r_index;
        n_cur     = r_cur;
        n_saved   = r_saved;
        n_pending = r_pending;
        job.kind         = JOB_NONE;
        job.chan         = r_cur;
        job.link_quality = i_link_quality;
        job.receive_time = i_receive_time;
        job.frame_length = i_frame_length;
        unique case (i_op)
            OP_TICK: begin
                if (r_phase == 2'd3) begin
                    if (r_scan) begin
                        if (r_index > r_highest) begin
                            job.kind = JOB_SET_DONE;
                            job.chan = r_saved;
                            n_cur    = r_saved;
                            n_scan   = 1'b0;
                        end else begin
                            job.kind = JOB_SET_BEACON;
                            job.chan = r_index;
                            n_cur    = r_index;
                            n_index  = r_index + 8'd1;
                        end
                    end
                    n_phase = 2'd1;
                end else begin
                    if (r_phase == 2'd2 && r_scan && r_index <= r_highest) begin
                        job.kind = JOB_BEACON;
                    end
                    n_phase = r_phase + 2'd1;
                end
            end
            OP_HOST: begin
                if (r_pending) begin
                    n_pending = 1'b0;
                    if (!r_scan) begin
                        job.kind = JOB_SET;
                        job.chan = i_host_byte;
                        n_cur    = i_host_byte;
                    end
                end else begin
                    unique case (i_host_byte)
                        CMD_CHANGE_CHAN: n_pending = 1'b1;
                        CMD_BEACON:      job.kind = JOB_BEACON;
                        CMD_START_SCAN: begin
                            n_scan  = 1'b1;
                            n_index = 8'd0;
                            n_saved = r_cur;
                        end
                        default: ;
                    endcase
                end
            end
            OP_HEADER: begin
                job.kind = JOB_HEADER;
            end
            default: begin
                job.kind = JOB_PAYLOAD;
                job.chan = i_payload_byte;
            end
        endcase
    end

    assign o_push = i_accept && (job.kind != JOB_NONE);
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_highest <= HIGHEST_RESET;
            r_phase   <= 2'd0;
            r_scan    <= 1'b0;
            r_index   <= 8'd0;
            r_cur     <= 8'd0;
            r_pending <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_highest <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_phase   <= n_phase;
                r_scan    <= n_scan;
                r_index   <= n_index;
                r_cur     <= n_cur;
                r_pending <= n_pending;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_saved <= n_saved;
        end
    end

endmodule
`default_nettype wire

>>> design/rcsc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcsc_queue
// Short job queue between front end and back end.
// ----------------------------------------------------------------------------
module rcsc_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  rcsc_pkg::t_job      i_job,
    input  wire                 i_pop,
    output logic                o_full,
    output logic                o_empty,
    output rcsc_pkg::t_job      o_job
);
    import rcsc_pkg::*;

    t_job                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr_ptr;
    logic [QUEUE_AW-1:0]  r_rd_ptr;
    logic [QUEUE_AW:0]    r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            priority if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> design/rcsc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcsc_back
// Back end: expands the job at the queue head into result words, one per
// cycle while the output is taken, into an output register.
// ----------------------------------------------------------------------------
module rcsc_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_empty,
    input  rcsc_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [1:0]          o_kind,
    output logic [7:0]          o_value,
    output logic                o_last
);
    import rcsc_pkg::*;

    logic [2:0] r_step;
    logic       r_valid;
    logic [1:0] r_kind;
    logic [7:0] r_value;
    logic       r_last;
    logic       load;
    logic [1:0] w_kind;
    logic [7:0] w_value;
    logic       w_last;

    always_comb begin
        w_kind  = KIND_HOST;
        w_value = 8'd0;
        w_last  = 1'b0;
        unique case (i_job.kind)
            JOB_BEACON: begin
                w_kind = KIND_BEACON;
                w_last = 1'b1;
            end
            JOB_PAYLOAD: begin
                w_value = i_job.chan;
                w_last  = 1'b1;
            end
            JOB_SET, JOB_SET_DONE, JOB_SET_BEACON: begin
                unique case (r_step)
                    3'd0: begin
                        w_kind  = KIND_TUNE;
                        w_value = i_job.chan;
                    end
                    3'd1: w_value = RPT_CHANNEL_IS;
                    3'd2: begin
                        w_value = i_job.chan;
                        w_last  = (i_job.kind == JOB_SET);
                    end
                    default: begin
                        w_last = 1'b1;
                        if (i_job.kind == JOB_SET_BEACON) begin
                            w_kind = KIND_BEACON;
                        end else begin
                            w_value = RPT_SCAN_DONE;
                        end
                    end
                endcase
            end
            JOB_HEADER: begin
                unique case (r_step)
                    3'd0: w_value = RPT_RECEIVED;
                    3'd1: w_value = i_job.chan;
                    3'd2: w_value = i_job.link_quality;
                    3'd3: w_value = i_job.receive_time[7:0];
                    3'd4: w_value = i_job.receive_time[15:8];
                    3'd5: w_value = i_job.receive_time[23:16];
                    3'd6: w_value = i_job.receive_time[31:24];
                    default: begin
                        w_value = {1'b0, i_job.frame_length};
                        w_last  = 1'b1;
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign load    = !i_empty && (!r_valid || i_ready);
    assign o_pop   = load && w_last;
    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_value = r_value;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_step  <= w_last ? 3'd0 : r_step + 3'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= w_kind;
            r_value <= w_value;
            r_last  <= w_last;
        end
    end

endmodule
`default_nettype wire
